/* src/tds_pkg.sv */
// ----------------------------------------------------------------------------
// tds_pkg
// shared types and constants of the tlv stream deframer
// ----------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

    // most extended length bytes after a 0x80-prefixed length byte
    localparam int unsigned MAX_EXT_LEN_BYTES = 2;

    localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
    localparam logic [6:0] LEN_COUNT_MAX = 7'(MAX_EXT_LEN_BYTES);
    localparam logic [1:0] MIN_FRAME_BYTES = 2'd3;

    // role of a word within the payload
    typedef enum logic [1:0] {
        ROLE_KEY     = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_IGNORED = 2'd3
    } t_role;

    // payload status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BADLEN  = 2'd2,
        ST_OVERRUN = 2'd3
    } t_status;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_KEY = 5'b00001,
        PH_LEN = 5'b00010,
        PH_EXT = 5'b00100,
        PH_VAL = 5'b01000,
        PH_ERR = 5'b10000
    } t_phase;

    typedef struct packed {
        t_role       byte_role;
        logic [7:0]  field_key;
        logic [15:0] field_length;
        logic        header_done;
        logic [7:0]  value_byte;
        logic [15:0] value_index;
        logic        field_done;
        logic        frame_done;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

/* src/tds_in_if.sv */
// ----------------------------------------------------------------------------
// tds_in_if
// input word channel: one payload byte and its end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface tds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* src/tds_out_if.sv */
// ----------------------------------------------------------------------------
// tds_out_if
// result word channel: role and field position of one payload byte
// ----------------------------------------------------------------------------
`default_nettype none

interface tds_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        byte_role;
    logic [7:0]        field_key;
    logic [15:0]       field_length;
    logic              header_done;
    logic [7:0]        value_byte;
    logic [15:0]       value_index;
    logic              field_done;
    logic              frame_done;
    logic [1:0]        status;

    modport source (
        output valid, output byte_role, output field_key, output field_length,
        output header_done, output value_byte, output value_index,
        output field_done, output frame_done, output status, input ready
    );
    modport sink (
        input valid, input byte_role, input field_key, input field_length,
        input header_done, input value_byte, input value_index,
        input field_done, input frame_done, input status, output ready
    );
endinterface

`default_nettype wire

/* src/tds_parser.sv */
// ----------------------------------------------------------------------------
// tds_parser
// parse state and one-word step logic of the tlv deframer
// ----------------------------------------------------------------------------
`default_nettype none

module tds_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output tds_pkg::t_result     o_result
);

    tds_pkg::t_phase  r_phase,      n_phase;
    logic [7:0]       r_key,        n_key;
    logic [15:0]      r_len_acc,    n_len_acc;
    logic [1:0]       r_ext_left,   n_ext_left;
    logic [15:0]      r_val_left,   n_val_left;
    logic [15:0]      r_val_pos,    n_val_pos;
    logic [1:0]       r_count,      n_count;
    tds_pkg::t_status r_error,      n_error;

    logic [6:0]       len_count;
    logic [15:0]      hdr_len;
    logic             hdr_end;
    logic [15:0]      ext_acc;
    logic [1:0]       ext_dec;
    logic [1:0]       cnt_inc;
    tds_pkg::t_status err_out;

    assign len_count = i_data_byte[6:0];
    assign ext_acc   = {r_len_acc[7:0], i_data_byte};
    assign ext_dec   = r_ext_left - 2'd1;
    assign cnt_inc   = (r_count == tds_pkg::MIN_FRAME_BYTES) ? r_count : r_count + 2'd1;

    always_comb begin
        o_result   = '0;
        n_phase    = r_phase;
        n_key      = r_key;
        n_len_acc  = r_len_acc;
        n_ext_left = r_ext_left;
        n_val_left = r_val_left;
        n_val_pos  = r_val_pos;
        n_count    = cnt_inc;
        n_error    = r_error;
        hdr_end    = 1'b0;
        hdr_len    = '0;

        case (r_phase)
            tds_pkg::PH_KEY: begin
                o_result.byte_role = tds_pkg::ROLE_KEY;
                o_result.field_key = i_data_byte;
                n_key              = i_data_byte;
                n_phase            = tds_pkg::PH_LEN;
            end
            tds_pkg::PH_LEN: begin
                o_result.byte_role = tds_pkg::ROLE_LENGTH;
                o_result.field_key = r_key;
                if (i_data_byte < tds_pkg::LEN_LONG_FLAG) begin
                    hdr_end = 1'b1;
                    hdr_len = {8'd0, i_data_byte};
                end else if (len_count == 7'd0 || len_count > tds_pkg::LEN_COUNT_MAX) begin
                    n_error = tds_pkg::ST_BADLEN;
                    n_phase = tds_pkg::PH_ERR;
                end else begin
                    n_ext_left = len_count[1:0];
                    n_len_acc  = '0;
                    n_phase    = tds_pkg::PH_EXT;
                end
            end
            tds_pkg::PH_EXT: begin
                o_result.byte_role = tds_pkg::ROLE_LENGTH;
                o_result.field_key = r_key;
                n_len_acc          = ext_acc;
                n_ext_left         = ext_dec;
                if (ext_dec == 2'd0) begin
                    hdr_end = 1'b1;
                    hdr_len = ext_acc;
                end
            end
            tds_pkg::PH_VAL: begin
                o_result.byte_role    = tds_pkg::ROLE_VALUE;
                o_result.field_key    = r_key;
                o_result.field_length = r_len_acc;
                o_result.value_byte   = i_data_byte;
                o_result.value_index  = r_val_pos;
                n_val_pos             = r_val_pos + 16'd1;
                n_val_left            = r_val_left - 16'd1;
                if (r_val_left == 16'd1) begin
                    o_result.field_done = 1'b1;
                    n_phase             = tds_pkg::PH_KEY;
                end
            end
            default: begin
                o_result.byte_role = tds_pkg::ROLE_IGNORED;
                n_phase            = tds_pkg::PH_ERR;
            end
        endcase

        // header complete: zero length closes the field at once
        if (hdr_end) begin
            n_len_acc             = hdr_len;
            o_result.field_length = hdr_len;
            o_result.header_done  = 1'b1;
            if (hdr_len == 16'd0) begin
                o_result.field_done = 1'b1;
                n_phase             = tds_pkg::PH_KEY;
            end else begin
                n_val_left = hdr_len;
                n_val_pos  = '0;
                n_phase    = tds_pkg::PH_VAL;
            end
        end

        err_out = n_error;
        if (i_last_byte) begin
            if (err_out == tds_pkg::ST_OK) begin
                if (n_phase == tds_pkg::PH_EXT) begin
                    err_out = tds_pkg::ST_BADLEN;
                end else if (n_phase == tds_pkg::PH_VAL) begin
                    err_out = tds_pkg::ST_OVERRUN;
                end
            end
            if (cnt_inc < tds_pkg::MIN_FRAME_BYTES) begin
                err_out = tds_pkg::ST_SHORT;
            end
            o_result.frame_done = 1'b1;
            // back to the idle state for the next payload
            n_phase    = tds_pkg::PH_KEY;
            n_key      = '0;
            n_len_acc  = '0;
            n_ext_left = '0;
            n_val_left = '0;
            n_val_pos  = '0;
            n_count    = '0;
            n_error    = tds_pkg::ST_OK;
        end
        o_result.status = err_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tds_pkg::PH_KEY;
            r_key      <= '0;
            r_len_acc  <= '0;
            r_ext_left <= '0;
            r_val_left <= '0;
            r_val_pos  <= '0;
            r_count    <= '0;
            r_error    <= tds_pkg::ST_OK;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_key      <= n_key;
            r_len_acc  <= n_len_acc;
            r_ext_left <= n_ext_left;
            r_val_left <= n_val_left;
            r_val_pos  <= n_val_pos;
            r_count    <= n_count;
            r_error    <= n_error;
        end
    end

    // an error phase always has an error held
    a_err_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tds_pkg::PH_ERR |-> r_error != tds_pkg::ST_OK)
        else $error("error phase without held error");

    // value phase always has bytes left
    a_val_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tds_pkg::PH_VAL |-> r_val_left != 16'd0)
        else $error("value phase with no bytes left");

    // extended length phase always has length bytes left
    a_ext_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tds_pkg::PH_EXT |-> r_ext_left != 2'd0)
        else $error("extended length phase with no bytes left");

endmodule

`default_nettype wire

/* src/tlv_stream_deframer.sv */
// ----------------------------------------------------------------------------
// tlv_stream_deframer
// splits a byte stream into key-length-value fields, one result word per byte
// ----------------------------------------------------------------------------
//
//  port     dir   handshake      payload
//  i_in     in    valid/ready    data_byte[7:0], last_byte
//  o_out    out   valid/ready    byte_role, field_key, field_length, header_done,
//                                value_byte, value_index, field_done,
//                                frame_done, status
//
//  one word per cycle sustained while o_out is not stalled; a word passes the input
//  register, then the result one; tds_parser holds the parse state loop (phase,
//  length, counters), stepped as the input register moves into the result register
//  reset (i_rst_n, synchronous) empties both registers and returns the parser
//  to expecting a key byte
//  a stalled output holds its word; input keeps being taken while the input
//  register can drain into the result register in the same cycle
//
`default_nettype none

module tlv_stream_deframer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tds_in_if.sink      i_in,
    tds_out_if.source   o_out
);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_in_last;

    // result register
    logic             r_out_valid;
    tds_pkg::t_result r_out;

    tds_pkg::t_result step_result;
    logic             advance;
    logic             in_take;

    // input word moves on when the result register is free or being emptied
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take = i_in.valid && i_in.ready;

    tds_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.byte_role    = r_out.byte_role;
    assign o_out.field_key    = r_out.field_key;
    assign o_out.field_length = r_out.field_length;
    assign o_out.header_done  = r_out.header_done;
    assign o_out.value_byte   = r_out.value_byte;
    assign o_out.value_index  = r_out.value_index;
    assign o_out.field_done   = r_out.field_done;
    assign o_out.frame_done   = r_out.frame_done;
    assign o_out.status       = r_out.status;

    // ignored words only follow a held error
    a_ignored_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.byte_role == tds_pkg::ROLE_IGNORED
        |-> r_out.status != tds_pkg::ST_OK)
        else $error("ignored word with ok status");

    // value index stays inside the decoded length
    a_val_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.byte_role == tds_pkg::ROLE_VALUE
        |-> r_out.value_index < r_out.field_length)
        else $error("value index beyond field length");

    // header completion only on a length word
    a_hdr_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.header_done |-> r_out.byte_role == tds_pkg::ROLE_LENGTH)
        else $error("header done on a non-length word");

endmodule

`default_nettype wire
